// File: hw/rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// Ghost point classifier package
// Shared widths, codes, the scan status struct and the count clamp functions.
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

  // Grid limits and the widths that follow from them.
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 4096;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COLS_W      = 11;  // column_count register width
  localparam int ROWS_W      = 13;  // row_count register width
  localparam int CFG_W       = 13;  // widest configuration register
  localparam int LEVEL_W     = 32;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COLS_W-1:0] cols_t;
  typedef logic [ROWS_W-1:0] rows_t;

  // Point classes.
  typedef enum logic [1:0] {
    CLASS_FLUID = 2'd0,
    CLASS_GHOST = 2'd1,
    CLASS_SOLID = 2'd2
  } class_t;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Scan position and boundary flags that the classifier needs for the
  // item being accepted.
  typedef struct packed {
    logic pending;       // last row awaits drain items
    row_t row;           // row of the incoming sample
    col_t column;        // column of the incoming sample
    col_t drain_column;  // column of the next drained point
    row_t last_row;      // row_count - 1
    logic row_first;     // incoming sample is in row 0
    logic up_valid;      // classified point is not in row 0
    logic col_inner;     // classified point is not in the first or last column
    logic col_end;       // incoming sample closes its row
    logic drain_end;     // next drained point is the last of the frame
  } scan_t;

  // Zero counts as one and values above the limit saturate.
  function automatic rows_t clamp_rows(input logic [ROWS_W-1:0] v);
    rows_t r;
    if (v == '0) begin
      r = rows_t'(1);
    end else if (v > rows_t'(MAX_ROWS)) begin
      r = rows_t'(MAX_ROWS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic cols_t clamp_cols(input logic [COLS_W-1:0] v);
    cols_t r;
    if (v == '0) begin
      r = cols_t'(1);
    end else if (v > cols_t'(MAX_COLUMNS)) begin
      r = cols_t'(MAX_COLUMNS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gpc_ram.sv
// ----------------------------------------------------------------------------
// Generic line buffer RAM
// One write port and one read port with registered read data; a read of the
// address being written returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output      logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gpc_scan.sv
// ----------------------------------------------------------------------------
// Ghost point classifier scan control
// Holds the row and column counters, the drain state and the frame size
// registers, and issues the line buffer read addresses for the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_scan
  import gpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_accept,
  input  wire logic             kind,
  output      scan_t            scan,
  output      col_t             rd_addr_center,
  output      col_t             rd_addr_right
);

  rows_t rows;
  cols_t cols;
  row_t  row,          row_next;
  col_t  column,       column_next;
  col_t  drain_column, drain_column_next;
  logic  pending,      pending_next;

  row_t  eff_row;
  col_t  eff_col;
  logic  col_end;
  logic  row_end;
  logic  drain_end;

  // A sample that arrives while the drain is pending starts a new frame.
  always_comb begin
    eff_row   = pending ? '0 : row;
    eff_col   = pending ? '0 : column;
    col_end   = (cols_t'(eff_col) + cols_t'(1)) >= cols;
    row_end   = (rows_t'(eff_row) + rows_t'(1)) >= rows;
    drain_end = (cols_t'(drain_column) + cols_t'(1)) >= cols;
  end

  always_comb begin
    row_next          = row;
    column_next       = column;
    drain_column_next = drain_column;
    pending_next      = pending;
    if (in_accept) begin
      if (kind == KIND_DRAIN) begin
        if (pending) begin
          if (drain_end) begin
            pending_next      = 1'b0;
            drain_column_next = '0;
          end else begin
            drain_column_next = drain_column + col_t'(1);
          end
        end
      end else begin
        pending_next      = 1'b0;
        drain_column_next = '0;
        row_next          = eff_row;
        if (col_end) begin
          column_next = '0;
          if (row_end) begin
            row_next     = '0;
            pending_next = 1'b1;
          end else begin
            row_next = eff_row + row_t'(1);
          end
        end else begin
          column_next = eff_col + col_t'(1);
        end
      end
    end
  end

  // Addresses for the item that follows; the RAMs register the read data.
  assign rd_addr_center = pending_next ? drain_column_next : column_next;
  assign rd_addr_right  = column_next + col_t'(1);

  always_comb begin
    scan.pending      = pending;
    scan.row          = eff_row;
    scan.column       = eff_col;
    scan.drain_column = drain_column;
    scan.last_row     = row_t'(rows - rows_t'(1));
    scan.row_first    = (eff_row == '0);
    scan.up_valid     = (eff_row > row_t'(1));
    scan.col_inner    = (eff_col != '0) && ((cols_t'(eff_col) + cols_t'(2)) <= cols);
    scan.col_end      = col_end;
    scan.drain_end    = drain_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= rows_t'(64);
      cols         <= cols_t'(64);
      row          <= '0;
      column       <= '0;
      drain_column <= '0;
      pending      <= 1'b0;
    end else begin
      row          <= row_next;
      column       <= column_next;
      drain_column <= drain_column_next;
      pending      <= pending_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROW_COUNT:    rows <= clamp_rows(cfg_data[ROWS_W-1:0]);
          REG_COLUMN_COUNT: cols <= clamp_cols(cfg_data[COLS_W-1:0]);
          default:          rows <= rows;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gpc_classify.sv
// ----------------------------------------------------------------------------
// Ghost point classifier stencil and result register
// Classifies the point one row above the incoming sample from its four
// neighbor signs and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_classify
  import gpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_accept,
  input  wire logic       kind,
  input  wire logic       here_solid,
  input  wire scan_t      scan,
  input  wire logic       up_solid,
  input  wire logic       center_solid,
  input  wire logic       right_solid,
  input  wire logic       out_stall,
  output      logic       wr_en,
  output      logic       out_valid,
  output      logic [1:0] point_class,
  output      row_t       row_index,
  output      col_t       column_index,
  output      logic       last_point
);

  logic   left_solid, left_solid_next;
  logic   res_valid;
  class_t res_class;
  row_t   res_row;
  col_t   res_col;
  logic   res_last;
  logic   ghost;

  // Any fluid neighbor turns an inner solid point into a ghost point.
  assign ghost = scan.up_valid && scan.col_inner &&
                 (!up_solid || !here_solid || !left_solid || !right_solid);

  always_comb begin
    res_valid       = 1'b0;
    res_class       = CLASS_FLUID;
    res_row         = scan.row - row_t'(1);
    res_col         = scan.column;
    res_last        = 1'b0;
    wr_en           = 1'b0;
    left_solid_next = left_solid;
    if (in_accept) begin
      if (kind == KIND_DRAIN) begin
        res_valid = scan.pending;
        res_class = center_solid ? CLASS_SOLID : CLASS_FLUID;
        res_row   = scan.last_row;
        res_col   = scan.drain_column;
        res_last  = scan.drain_end;
      end else begin
        wr_en           = 1'b1;
        res_valid       = !scan.row_first;
        res_class       = !center_solid ? CLASS_FLUID :
                          (ghost ? CLASS_GHOST : CLASS_SOLID);
        left_solid_next = scan.col_end ? 1'b0 : center_solid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      left_solid <= 1'b0;
    end else begin
      left_solid <= left_solid_next;
      if (in_accept) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      point_class  <= res_class;
      row_index    <= res_row;
      column_index <= res_col;
      last_point   <= res_last;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ghost_point_classifier_unit.sv
// ----------------------------------------------------------------------------
// Ghost point classifier
// Streams level-set samples in raster order and labels each grid point as
// fluid, ghost or solid, one row behind the input.
// ----------------------------------------------------------------------------
// The block accepts one item in every unstalled cycle and returns each result
// from a result register in the cycle after the item that causes it is
// accepted. Samples arrive row by row with the column running fastest; the
// sample at row r, column c produces the class of the point at row r-1,
// column c, so samples of row 0 produce nothing. After the last sample of a
// frame, drain items produce the last row one point per item, and the last
// of them carries last_point. A drain item with no row pending produces
// nothing, and a sample sent while the drain is still pending abandons the
// drain and starts a new frame. The rate is set by the single pass through
// the stencil: the signs of the two rows above the incoming sample live in
// three 1024 x 1 line buffer RAMs (one for the older row, two copies of the
// previous row for the center and right neighbors), whose addresses for the
// next item are issued from the next scan position so that their registered
// read data is ready when that item arrives. The line buffers need no
// clearing after reset. The input stalls only while a result is held and the
// output side stalls. row_count and column_count must be written through
// the configuration port while the block is idle (not enforced by the block);
// zero counts as one and values beyond 4096 rows or 1024 columns saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ghost_point_classifier_unit
  import gpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // item input
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               kind,
  input  wire logic [LEVEL_W-1:0] level_value,
  // result output
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [1:0]         point_class,
  output      logic [ROW_W-1:0]   row_index,
  output      logic [COL_W-1:0]   column_index,
  output      logic               last_point,
  // configuration
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  logic  in_accept;
  scan_t scan;
  col_t  rd_addr_center;
  col_t  rd_addr_right;
  logic  wr_en;
  logic  up_solid;
  logic  center_solid;
  logic  right_solid;

  // A new item can enter whenever the result register is free or is being
  // emptied in the same cycle.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  gpc_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_accept      (in_accept),
    .kind           (kind),
    .scan           (scan),
    .rd_addr_center (rd_addr_center),
    .rd_addr_right  (rd_addr_right)
  );

  // Signs of the row two above the incoming sample.
  gpc_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_older_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (scan.column),
    .wdata (center_solid),
    .raddr (rd_addr_center),
    .rdata (up_solid)
  );

  // Signs of the row just above, read at the sample column.
  gpc_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_prev_center_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (scan.column),
    .wdata (level_value[LEVEL_W-1]),
    .raddr (rd_addr_center),
    .rdata (center_solid)
  );

  // Same row, second copy read one column to the right.
  gpc_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_prev_right_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (scan.column),
    .wdata (level_value[LEVEL_W-1]),
    .raddr (rd_addr_right),
    .rdata (right_solid)
  );

  gpc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .kind         (kind),
    .here_solid   (level_value[LEVEL_W-1]),
    .scan         (scan),
    .up_solid     (up_solid),
    .center_solid (center_solid),
    .right_solid  (right_solid),
    .out_stall    (out_stall),
    .wr_en        (wr_en),
    .out_valid    (out_valid),
    .point_class  (point_class),
    .row_index    (row_index),
    .column_index (column_index),
    .last_point   (last_point)
  );

  // Drained points have no neighbor test, so the frame's last point is
  // never a ghost.
  a_last_not_ghost: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> point_class != CLASS_GHOST)
    else $error("last point of frame classified as ghost");

  // Ghost points never sit on the top row or the left column.
  a_ghost_inner: assert property (@(posedge clk) disable iff (rst)
    out_valid && (point_class == CLASS_GHOST) |->
      (row_index != '0) && (column_index != '0))
    else $error("ghost point on grid border");

  // A sample below the first row always leaves a result behind.
  a_sample_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && (kind == KIND_SAMPLE) && !scan.row_first |=> out_valid)
    else $error("sample below first row produced no result");

  // A first-row sample produces nothing.
  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    in_accept && (kind == KIND_SAMPLE) && scan.row_first |=> !out_valid)
    else $error("first-row sample produced a result");

endmodule

`default_nettype wire
